### hdl/mmm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmm_pkg
// Shared constants, command codes and types of the Montgomery multiplier.
// ----------------------------------------------------------------------------
package mmm_pkg;

   localparam int LIMB_W    = 52;
   localparam int HALF_W    = 26;
   localparam int MAX_LIMBS = 32;
   localparam int IDX_W     = 5;
   localparam int CNT_W     = 6;
   localparam int ACC_DEPTH = 2 * MAX_LIMBS;
   localparam int ACC_AW    = 6;

   localparam logic [1:0] CMD_LOAD_MOD = 2'd0;
   localparam logic [1:0] CMD_LOAD_OPS = 2'd1;
   localparam logic [1:0] CMD_START    = 2'd2;

   localparam logic REG_NEG_INV = 1'b0;
   localparam logic REG_LIMBS   = 1'b1;

   typedef struct packed {
      logic [1:0]        cmd;
      logic [IDX_W-1:0]  idx;
      logic [LIMB_W-1:0] first;
      logic [LIMB_W-1:0] second;
   } q_entry_type;

   typedef struct packed {
      logic [LIMB_W-1:0] mu;
      logic [CNT_W-1:0]  n;
   } cfg_type;

endpackage

### hdl/mmm_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmm_queue
// Four-entry request queue between the front and the back.
// ----------------------------------------------------------------------------
module mmm_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  mmm_pkg::q_entry_type push_data,
   output logic                 full,
   input  logic                 pop,
   output mmm_pkg::q_entry_type pop_data,
   output logic                 empty
);

   mmm_pkg::q_entry_type mem_ff [4];
   logic [1:0] wp_ff, wp_in, rp_ff, rp_in;
   logic [2:0] cnt_ff, cnt_in;

   assign full     = (cnt_ff == 3'd4);
   assign empty    = (cnt_ff == 3'd0);
   assign pop_data = mem_ff[rp_ff];

   always_comb begin
      wp_in  = push ? wp_ff + 2'd1 : wp_ff;
      rp_in  = pop ? rp_ff + 2'd1 : rp_ff;
      cnt_in = cnt_ff + {2'b0, push} - {2'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wp_ff] <= push_data;
      end
   end

endmodule

### hdl/mmm_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmm_front
// Request intake: decodes the command, drops unknown codes, fills the queue.
// ----------------------------------------------------------------------------
module mmm_front (
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [1:0]                   req_cmd,
   input  logic [mmm_pkg::IDX_W-1:0]    req_limb_index,
   input  logic [mmm_pkg::LIMB_W-1:0]   req_first_limb,
   input  logic [mmm_pkg::LIMB_W-1:0]   req_second_limb,
   input  logic                         q_full,
   output logic                         q_push,
   output mmm_pkg::q_entry_type         q_data
);

   logic known;

   always_comb begin
      case (req_cmd)
         mmm_pkg::CMD_LOAD_MOD, mmm_pkg::CMD_LOAD_OPS, mmm_pkg::CMD_START: known = 1'b1;
         default: known = 1'b0;
      endcase
   end

   assign req_stall     = q_full;
   assign q_push        = req_valid && !q_full && known;
   assign q_data.cmd    = req_cmd;
   assign q_data.idx    = req_limb_index;
   assign q_data.first  = req_first_limb;
   assign q_data.second = req_second_limb;

endmodule

### hdl/mmm_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmm_back
// Limb stores, accumulator memory and the sequencer for product, reduction,
// final compare and subtract, and the result register.
// ----------------------------------------------------------------------------
module mmm_back (
   input  logic                        clock,
   input  logic                        reset,
   input  mmm_pkg::cfg_type            cfg,
   input  logic                        q_empty,
   input  mmm_pkg::q_entry_type        q_data,
   output logic                        q_pop,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [mmm_pkg::LIMB_W-1:0]  rsp_result_limb,
   output logic [mmm_pkg::IDX_W-1:0]   rsp_result_index,
   output logic                        rsp_last
);

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_CLR   = 4'd1;
   localparam logic [3:0] ST_XRD   = 4'd2;
   localparam logic [3:0] ST_XCAP  = 4'd3;
   localparam logic [3:0] ST_RRD   = 4'd4;
   localparam logic [3:0] ST_RMUL  = 4'd5;
   localparam logic [3:0] ST_RWR   = 4'd6;
   localparam logic [3:0] ST_PRD   = 4'd7;
   localparam logic [3:0] ST_PWR   = 4'd8;
   localparam logic [3:0] ST_QRD   = 4'd9;
   localparam logic [3:0] ST_QCAP  = 4'd10;
   localparam logic [3:0] ST_QMUL  = 4'd11;
   localparam logic [3:0] ST_CRD   = 4'd12;
   localparam logic [3:0] ST_CCMP  = 4'd13;
   localparam logic [3:0] ST_ORD   = 4'd14;
   localparam logic [3:0] ST_OEMIT = 4'd15;

   localparam int LW = mmm_pkg::LIMB_W;
   localparam int HW = mmm_pkg::HALF_W;
   localparam int IW = mmm_pkg::IDX_W;
   localparam int NW = mmm_pkg::CNT_W;
   localparam int AW = mmm_pkg::ACC_AW;

   // memories
   logic [LW-1:0] mod_mem [mmm_pkg::MAX_LIMBS];
   logic [LW-1:0] opa_mem [mmm_pkg::MAX_LIMBS];
   logic [LW-1:0] opb_mem [mmm_pkg::MAX_LIMBS];
   logic [LW-1:0] acc_mem [mmm_pkg::ACC_DEPTH];
   logic [LW-1:0] mod_q_ff, opa_q_ff, opb_q_ff, acc_q_ff;

   logic [3:0]    st_ff, st_in;
   logic [IW-1:0] i_ff, i_in, j_ff, j_in;
   logic [NW:0]   k_ff, k_in;
   logic [AW-1:0] clr_ff, clr_in;
   logic [1:0]    mk_ff, mk_in;
   logic          red_ff, red_in, cb_ff, cb_in, ge_ff, ge_in, bw_ff, bw_in;
   logic [LW-1:0] x_ff, x_in;
   logic [2*LW-1:0] prod_ff, prod_in, prod_sum, pp_sh;
   logic [LW:0]   c_ff, c_in;
   logic          ov_ff, ov_in;
   logic [LW-1:0] ol_ff, ol_in;
   logic [IW-1:0] oi_ff, oi_in;
   logic          olast_ff, olast_in;

   logic [AW-1:0] acc_a;
   logic          acc_we;
   logic [LW-1:0] acc_wd;
   logic [IW-1:0] st_a;
   logic          mod_we, ops_we;

   logic [NW-1:0] n;
   logic          last_i, last_j, out_free, cb_next;
   logic [HW-1:0] ah, bh;
   logic [LW-1:0] mb, pp;
   logic [LW+1:0] t;
   logic [LW:0]   diff;

   assign n        = cfg.n;
   assign last_i   = ({1'b0, i_ff} == n - NW'(1));
   assign last_j   = ({1'b0, j_ff} == n - NW'(1));
   assign out_free = !ov_ff || !rsp_stall;
   assign cb_next  = cb_ff ^ c_ff[0];

   // shared 26x26 multiplier, one partial product per cycle
   always_comb begin
      if (st_ff == ST_QMUL) begin
         mb = cfg.mu;
      end else begin
         mb = red_ff ? mod_q_ff : opa_q_ff;
      end
      ah = mk_ff[0] ? x_ff[LW-1:HW] : x_ff[HW-1:0];
      bh = mk_ff[1] ? mb[LW-1:HW] : mb[HW-1:0];
      pp = {{HW{1'b0}}, ah} * {{HW{1'b0}}, bh};
      case (mk_ff)
         2'd0:    pp_sh = {{LW{1'b0}}, pp};
         2'd3:    pp_sh = {pp, {LW{1'b0}}};
         default: pp_sh = {{HW{1'b0}}, pp, {HW{1'b0}}};
      endcase
      prod_sum = (mk_ff == 2'd0) ? pp_sh : prod_ff + pp_sh;
   end

   // address selection
   always_comb begin
      case (st_ff)
         ST_CLR:                  acc_a = clr_ff;
         ST_RRD, ST_RMUL, ST_RWR: acc_a = AW'({1'b0, i_ff} + {1'b0, j_ff});
         ST_PRD, ST_PWR:          acc_a = k_ff[AW-1:0];
         ST_CRD, ST_CCMP, ST_ORD, ST_OEMIT: acc_a = AW'(n + {1'b0, i_ff});
         default:                 acc_a = AW'(i_ff);
      endcase
      case (st_ff)
         ST_RRD, ST_RMUL, ST_RWR: st_a = j_ff;
         default:                 st_a = i_ff;
      endcase
   end

   always_comb begin
      st_in    = st_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      k_in     = k_ff;
      clr_in   = clr_ff;
      mk_in    = mk_ff;
      red_in   = red_ff;
      cb_in    = cb_ff;
      ge_in    = ge_ff;
      bw_in    = bw_ff;
      x_in     = x_ff;
      prod_in  = prod_ff;
      c_in     = c_ff;
      ov_in    = ov_ff && rsp_stall;
      ol_in    = ol_ff;
      oi_in    = oi_ff;
      olast_in = olast_ff;
      q_pop    = 1'b0;
      mod_we   = 1'b0;
      ops_we   = 1'b0;
      acc_we   = 1'b0;
      acc_wd   = '0;
      t        = '0;
      diff     = '0;
      case (st_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               q_pop = 1'b1;
               case (q_data.cmd)
                  mmm_pkg::CMD_LOAD_MOD: mod_we = 1'b1;
                  mmm_pkg::CMD_LOAD_OPS: ops_we = 1'b1;
                  default: begin
                     clr_in = '0;
                     cb_in  = 1'b0;
                     st_in  = ST_CLR;
                  end
               endcase
            end
         end
         ST_CLR: begin
            acc_we = 1'b1;
            clr_in = clr_ff + AW'(1);
            if ({1'b0, clr_ff} == {n, 1'b0} - (NW+1)'(1)) begin
               i_in   = '0;
               red_in = 1'b0;
               st_in  = ST_XRD;
            end
         end
         ST_XRD: st_in = ST_XCAP;
         ST_XCAP: begin
            x_in  = opb_q_ff;
            j_in  = '0;
            c_in  = '0;
            st_in = ST_RRD;
         end
         ST_RRD: begin
            mk_in = '0;
            st_in = ST_RMUL;
         end
         ST_RMUL: begin
            prod_in = prod_sum;
            mk_in   = mk_ff + 2'd1;
            if (mk_ff == 2'd3) st_in = ST_RWR;
         end
         ST_RWR: begin
            t      = {2'b0, acc_q_ff} + {2'b0, prod_ff[LW-1:0]} + {1'b0, c_ff};
            acc_we = 1'b1;
            acc_wd = t[LW-1:0];
            c_in   = {{(LW-1){1'b0}}, t[LW+1:LW]} + {1'b0, prod_ff[2*LW-1:LW]};
            j_in   = j_ff + IW'(1);
            if (last_j) begin
               k_in  = {2'b0, i_ff} + {1'b0, n};
               st_in = ST_PRD;
            end else begin
               st_in = ST_RRD;
            end
         end
         ST_PRD: begin
            if (k_ff == {n, 1'b0} || c_ff == '0) begin
               cb_in = cb_next;
               i_in  = i_ff + IW'(1);
               if (!last_i) begin
                  st_in = red_ff ? ST_QRD : ST_XRD;
               end else if (!red_ff) begin
                  red_in = 1'b1;
                  i_in   = '0;
                  st_in  = ST_QRD;
               end else if (cb_next) begin
                  ge_in = 1'b1;
                  bw_in = 1'b0;
                  i_in  = '0;
                  st_in = ST_ORD;
               end else begin
                  i_in  = IW'(n - NW'(1));
                  st_in = ST_CRD;
               end
            end else begin
               st_in = ST_PWR;
            end
         end
         ST_PWR: begin
            t      = {2'b0, acc_q_ff} + {1'b0, c_ff};
            acc_we = 1'b1;
            acc_wd = t[LW-1:0];
            c_in   = {{(LW-1){1'b0}}, t[LW+1:LW]};
            k_in   = k_ff + (NW+1)'(1);
            st_in  = ST_PRD;
         end
         ST_QRD: st_in = ST_QCAP;
         ST_QCAP: begin
            x_in  = acc_q_ff;
            mk_in = '0;
            st_in = ST_QMUL;
         end
         ST_QMUL: begin
            prod_in = prod_sum;
            mk_in   = mk_ff + 2'd1;
            if (mk_ff == 2'd3) begin
               x_in  = prod_sum[LW-1:0];
               j_in  = '0;
               c_in  = '0;
               st_in = ST_RRD;
            end
         end
         ST_CRD: st_in = ST_CCMP;
         ST_CCMP: begin
            bw_in = 1'b0;
            if (acc_q_ff != mod_q_ff) begin
               ge_in = acc_q_ff > mod_q_ff;
               i_in  = '0;
               st_in = ST_ORD;
            end else if (i_ff == '0) begin
               ge_in = 1'b1;
               st_in = ST_ORD;
            end else begin
               i_in  = i_ff - IW'(1);
               st_in = ST_CRD;
            end
         end
         ST_ORD: st_in = ST_OEMIT;
         default: begin
            diff = {1'b0, acc_q_ff} - {1'b0, mod_q_ff} - {{LW{1'b0}}, bw_ff};
            if (out_free) begin
               ov_in    = 1'b1;
               ol_in    = ge_ff ? diff[LW-1:0] : acc_q_ff;
               oi_in    = i_ff;
               olast_in = last_i;
               bw_in    = diff[LW];
               i_in     = i_ff + IW'(1);
               st_in    = last_i ? ST_IDLE : ST_ORD;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE;
         ov_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         ov_ff <= ov_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff     <= i_in;
      j_ff     <= j_in;
      k_ff     <= k_in;
      clr_ff   <= clr_in;
      mk_ff    <= mk_in;
      red_ff   <= red_in;
      cb_ff    <= cb_in;
      ge_ff    <= ge_in;
      bw_ff    <= bw_in;
      x_ff     <= x_in;
      prod_ff  <= prod_in;
      c_ff     <= c_in;
      ol_ff    <= ol_in;
      oi_ff    <= oi_in;
      olast_ff <= olast_in;
   end

   always_ff @(posedge clock) begin
      if (mod_we) mod_mem[q_data.idx] <= q_data.first;
      if (ops_we) begin
         opa_mem[q_data.idx] <= q_data.first;
         opb_mem[q_data.idx] <= q_data.second;
      end
      mod_q_ff <= mod_mem[st_a];
      opa_q_ff <= opa_mem[st_a];
      opb_q_ff <= opb_mem[st_a];
   end

   always_ff @(posedge clock) begin
      if (acc_we) acc_mem[acc_a] <= acc_wd;
      acc_q_ff <= acc_mem[acc_a];
   end

   assign rsp_valid        = ov_ff;
   assign rsp_result_limb  = ol_ff;
   assign rsp_result_index = oi_ff;
   assign rsp_last         = olast_ff;

endmodule

### hdl/montgomery_modular_multiplier_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// montgomery_modular_multiplier_unit
// Montgomery product b*c*2^(-52n) mod m on 52-bit limbs, n up to 32.
// ----------------------------------------------------------------------------
// Loads are written to the limb stores once they reach the back end through a
// four-entry request queue. A start request clears the accumulator, then runs
// 2n limb rows, each limb product built in the shared 26x26 multiplier from
// partial products of the 26-bit halves plus read and write-back, each row
// ending in a carry ripple. Unless the top carry is set, a compare against the
// modulus from the top limb down follows, before the n result limbs stream out,
// least significant first.
module montgomery_modular_multiplier_unit (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [1:0]                  req_cmd,
   input  logic [mmm_pkg::IDX_W-1:0]   req_limb_index,
   input  logic [mmm_pkg::LIMB_W-1:0]  req_first_limb,
   input  logic [mmm_pkg::LIMB_W-1:0]  req_second_limb,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [mmm_pkg::LIMB_W-1:0]  rsp_result_limb,
   output logic [mmm_pkg::IDX_W-1:0]   rsp_result_index,
   output logic                        rsp_last,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [3:0]                  csr_paddr,
   input  logic [63:0]                 csr_pwdata,
   output logic [63:0]                 csr_prdata,
   output logic                        csr_pready
);

   logic [mmm_pkg::LIMB_W-1:0] mu_ff;
   logic [mmm_pkg::CNT_W-1:0]  lim_ff;
   logic                       wr;
   mmm_pkg::cfg_type           cfg;
   mmm_pkg::q_entry_type       push_data, pop_data;
   logic                       q_push, q_pop, q_full, q_empty;

   assign csr_pready = 1'b1;
   assign wr = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         mu_ff  <= mmm_pkg::LIMB_W'(1);
         lim_ff <= mmm_pkg::CNT_W'(1);
      end else if (wr) begin
         if (csr_paddr[3] == mmm_pkg::REG_NEG_INV) mu_ff <= csr_pwdata[mmm_pkg::LIMB_W-1:0];
         else lim_ff <= csr_pwdata[mmm_pkg::CNT_W-1:0];
      end
   end

   always_comb begin
      if (csr_paddr[3] == mmm_pkg::REG_LIMBS) begin
         csr_prdata = {{(64-mmm_pkg::CNT_W){1'b0}}, lim_ff};
      end else begin
         csr_prdata = {{(64-mmm_pkg::LIMB_W){1'b0}}, mu_ff};
      end
      cfg.mu = mu_ff;
      if (lim_ff == '0) cfg.n = mmm_pkg::CNT_W'(1);
      else if (lim_ff > mmm_pkg::CNT_W'(mmm_pkg::MAX_LIMBS)) cfg.n = mmm_pkg::CNT_W'(mmm_pkg::MAX_LIMBS);
      else cfg.n = lim_ff;
   end

   mmm_front u_front (
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_cmd         (req_cmd),
      .req_limb_index  (req_limb_index),
      .req_first_limb  (req_first_limb),
      .req_second_limb (req_second_limb),
      .q_full          (q_full),
      .q_push          (q_push),
      .q_data          (push_data)
   );

   mmm_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (push_data),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (pop_data),
      .empty     (q_empty)
   );

   mmm_back u_back (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg),
      .q_empty          (q_empty),
      .q_data           (pop_data),
      .q_pop            (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_result_limb  (rsp_result_limb),
      .rsp_result_index (rsp_result_index),
      .rsp_last         (rsp_last)
   );

   // queue never overfilled or drained past empty
   a_push_room: assert property (@(posedge clock) disable iff (reset) q_push |-> !q_full)
      else $error("push into full queue");
   a_pop_data: assert property (@(posedge clock) disable iff (reset) q_pop |-> !q_empty)
      else $error("pop from empty queue");
   a_pop_after_push: assert property (@(posedge clock) disable iff (reset)
      q_push && q_empty |=> !q_empty)
      else $error("pushed request lost");

endmodule
